// ===== rtl/core/scb_pkg.sv =====
// ----------------------------------------------------------------------------
// scb_pkg
// Types, constants and helper functions shared by the segment/circle
// bisection core, its controller and its datapath.
// ----------------------------------------------------------------------------
package scb_pkg;

	localparam int MAX_STEPS = 48;
	localparam int FRAC_BITS = 16;

	localparam int COORD_W = 32;
	localparam int CFG_W   = 31;
	localparam int STEP_W  = 7;
	localparam int SQ_W    = 64;
	localparam int R2_W    = 2 * CFG_W;

	localparam logic [CFG_W-1:0] RADIUS_RST = CFG_W'(64'd1 << FRAC_BITS);
	localparam logic [CFG_W-1:0] TOL_RST    = CFG_W'(16);

	// configuration register indexes
	localparam logic [0:0] CFG_RADIUS    = 1'b0;
	localparam logic [0:0] CFG_TOLERANCE = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
	} seg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] cross_x;
		logic signed [COORD_W-1:0] cross_y;
		logic [1:0]                status;
		logic [STEP_W-1:0]         steps_used;
	} res_t;

	typedef enum logic [1:0] {
		RES_FOUND      = 2'd0,
		RES_SAME_SIDE  = 2'd1,
		RES_STEP_LIMIT = 2'd2
	} res_code_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_RT,
		MUL_P1,
		MUL_P2,
		MUL_LEN,
		MUL_MID
	} mul_sel_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_SIDE1,
		ST_SIDE2,
		ST_LEN,
		ST_CHECK,
		ST_MID,
		ST_DONE
	} state_t;

	// side of a point against the circle: neither flag set means on it
	typedef struct packed {
		logic gt;
		logic lt;
	} side_t;

	typedef struct packed {
		logic      load;
		mul_sel_t  mul_sel;
		logic      lat_sq;
		logic      lat_s1;
		logic      lat_s2;
		logic      adv;
		logic      upd;
		logic      res_wr;
		res_code_t res_code;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		logic too_long;
		logic same_side;
		logic step_max;
		logic mid_on;
	} flags_t;

	// floor((a + b) / 2), exact
	function automatic logic signed [COORD_W-1:0] mid_pt(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [COORD_W:0] s;
		s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
		return s[COORD_W:1];
	endfunction

	// magnitude of a signed coordinate, fits unsigned 32 bits
	function automatic logic [COORD_W-1:0] mag32(input logic signed [COORD_W-1:0] v);
		logic [COORD_W-1:0] u;
		u = v;
		return v[COORD_W-1] ? (~u + 1'b1) : u;
	endfunction

	// magnitude of a coordinate difference, at most 2^32 - 1
	function automatic logic [COORD_W-1:0] mag33(input logic signed [COORD_W:0] v);
		logic [COORD_W:0] u;
		logic [COORD_W:0] n;
		u = v;
		n = ~u + 1'b1;
		return v[COORD_W] ? n[COORD_W-1:0] : u[COORD_W-1:0];
	endfunction

endpackage

// ===== rtl/core/scb_ctrl.sv =====
// ----------------------------------------------------------------------------
// scb_ctrl
// Sequencer for the bisection search: steps the datapath through the setup
// squarings, the length check and midpoint test of each halving, and the
// output handshake.
// ----------------------------------------------------------------------------
module scb_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            seg_valid,
	output logic            seg_ready,
	output logic            res_valid,
	input  logic            res_ready,
	input  scb_pkg::flags_t flags,
	output scb_pkg::cmd_t   cmd
);

	scb_pkg::state_t state_q;
	scb_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || res_ready;
	assign seg_ready = (state_q == scb_pkg::ST_IDLE);
	assign res_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			scb_pkg::ST_IDLE: begin
				if (seg_valid) state_d = scb_pkg::ST_INIT;
			end
			scb_pkg::ST_INIT:  state_d = scb_pkg::ST_SIDE1;
			scb_pkg::ST_SIDE1: state_d = scb_pkg::ST_SIDE2;
			scb_pkg::ST_SIDE2: state_d = scb_pkg::ST_LEN;
			scb_pkg::ST_LEN:   state_d = scb_pkg::ST_CHECK;
			scb_pkg::ST_CHECK: begin
				if (flags.same_side || !flags.too_long || flags.step_max)
					state_d = scb_pkg::ST_DONE;
				else
					state_d = scb_pkg::ST_MID;
			end
			scb_pkg::ST_MID: begin
				state_d = flags.mid_on ? scb_pkg::ST_DONE : scb_pkg::ST_LEN;
			end
			scb_pkg::ST_DONE: begin
				if (out_free) state_d = scb_pkg::ST_IDLE;
			end
			default: state_d = scb_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = scb_pkg::MUL_NONE;
		cmd.res_code = scb_pkg::RES_FOUND;
		case (state_q)
			scb_pkg::ST_IDLE: begin
				cmd.load = seg_valid;
			end
			scb_pkg::ST_INIT: begin
				cmd.mul_sel = scb_pkg::MUL_RT;
			end
			scb_pkg::ST_SIDE1: begin
				cmd.mul_sel = scb_pkg::MUL_P1;
				cmd.lat_sq  = 1'b1;
			end
			scb_pkg::ST_SIDE2: begin
				cmd.mul_sel = scb_pkg::MUL_P2;
				cmd.lat_s1  = 1'b1;
			end
			scb_pkg::ST_LEN: begin
				cmd.mul_sel = scb_pkg::MUL_LEN;
				cmd.lat_s2  = 1'b1;
			end
			scb_pkg::ST_CHECK: begin
				// square the midpoint now; it is only used if the search goes on
				cmd.mul_sel = scb_pkg::MUL_MID;
				if (flags.same_side) begin
					cmd.res_wr   = 1'b1;
					cmd.res_code = scb_pkg::RES_SAME_SIDE;
				end else if (!flags.too_long || flags.step_max) begin
					cmd.res_wr   = 1'b1;
					cmd.res_code = flags.too_long ? scb_pkg::RES_STEP_LIMIT
					                              : scb_pkg::RES_FOUND;
				end else begin
					cmd.adv = 1'b1;
				end
			end
			scb_pkg::ST_MID: begin
				if (flags.mid_on) begin
					cmd.res_wr   = 1'b1;
					cmd.res_code = scb_pkg::RES_FOUND;
				end else begin
					cmd.upd = 1'b1;
				end
			end
			scb_pkg::ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd.mul_sel = scb_pkg::MUL_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scb_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/core/scb_dpath.sv =====
// ----------------------------------------------------------------------------
// scb_dpath
// Datapath of the bisection search: configuration registers, interval
// endpoints, two registered squarers, the sum/compare stage and the output
// register.
// ----------------------------------------------------------------------------
module scb_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [0:0]                 cfg_idx,
	input  logic [scb_pkg::CFG_W-1:0]  cfg_wdata,
	input  scb_pkg::seg_t              seg,
	input  scb_pkg::cmd_t              cmd,
	output scb_pkg::flags_t            flags,
	output scb_pkg::res_t              res
);

	logic [scb_pkg::CFG_W-1:0] radius_q;
	logic [scb_pkg::CFG_W-1:0] tol_q;

	logic signed [scb_pkg::COORD_W-1:0] p1x_q, p1y_q, p2x_q, p2y_q;
	logic signed [scb_pkg::COORD_W-1:0] mx_q, my_q;
	logic signed [scb_pkg::COORD_W-1:0] mid_x, mid_y;
	logic [scb_pkg::STEP_W-1:0]         steps_q;
	logic [scb_pkg::R2_W-1:0]           r2_q;
	logic [scb_pkg::R2_W-1:0]           tol2_q;
	scb_pkg::side_t                     s1_q, s2_q, side_cur;
	scb_pkg::res_code_t                 code_q;
	scb_pkg::res_t                      res_q;

	logic [scb_pkg::COORD_W-1:0] opa, opb;
	logic [scb_pkg::SQ_W-1:0]    sqa, sqb;
	logic [scb_pkg::SQ_W-1:0]    pa_q, pb_q;
	logic [scb_pkg::SQ_W:0]      sum;
	logic                        keep_p2;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= scb_pkg::RADIUS_RST;
			tol_q    <= scb_pkg::TOL_RST;
		end else if (cfg_wen) begin
			case (cfg_idx)
				scb_pkg::CFG_RADIUS:    radius_q <= cfg_wdata;
				scb_pkg::CFG_TOLERANCE: tol_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign mid_x = scb_pkg::mid_pt(p1x_q, p2x_q);
	assign mid_y = scb_pkg::mid_pt(p1y_q, p2y_q);

	// squarer operands
	always_comb begin
		case (cmd.mul_sel)
			scb_pkg::MUL_RT: begin
				opa = {1'b0, radius_q};
				opb = {1'b0, tol_q};
			end
			scb_pkg::MUL_P1: begin
				opa = scb_pkg::mag32(p1x_q);
				opb = scb_pkg::mag32(p1y_q);
			end
			scb_pkg::MUL_P2: begin
				opa = scb_pkg::mag32(p2x_q);
				opb = scb_pkg::mag32(p2y_q);
			end
			scb_pkg::MUL_LEN: begin
				opa = scb_pkg::mag33({p1x_q[scb_pkg::COORD_W-1], p1x_q}
				                   - {p2x_q[scb_pkg::COORD_W-1], p2x_q});
				opb = scb_pkg::mag33({p1y_q[scb_pkg::COORD_W-1], p1y_q}
				                   - {p2y_q[scb_pkg::COORD_W-1], p2y_q});
			end
			scb_pkg::MUL_MID: begin
				opa = scb_pkg::mag32(mid_x);
				opb = scb_pkg::mag32(mid_y);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	assign sqa = opa * opa;
	assign sqb = opb * opb;

	always_ff @(posedge clk) begin
		pa_q <= sqa;
		pb_q <= sqb;
	end

	// sum of squares, compared against radius^2 or tolerance^2
	assign sum         = {1'b0, pa_q} + {1'b0, pb_q};
	assign side_cur.gt = sum > {3'b0, r2_q};
	assign side_cur.lt = sum < {3'b0, r2_q};

	assign flags.too_long  = sum[scb_pkg::SQ_W] || (sum[scb_pkg::SQ_W-1:0] > {2'b0, tol2_q});
	assign flags.same_side = (s1_q.gt && s2_q.gt) || (s1_q.lt && s2_q.lt);
	assign flags.step_max  = (steps_q == scb_pkg::STEP_W'(scb_pkg::MAX_STEPS));
	assign flags.mid_on    = !side_cur.gt && !side_cur.lt;

	// midpoint on the same side as the first end replaces the first end
	assign keep_p2 = (side_cur.gt && s1_q.gt) || (side_cur.lt && s1_q.lt);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p1x_q   <= seg.start_x;
			p1y_q   <= seg.start_y;
			p2x_q   <= seg.end_x;
			p2y_q   <= seg.end_y;
			mx_q    <= scb_pkg::mid_pt(seg.start_x, seg.end_x);
			my_q    <= scb_pkg::mid_pt(seg.start_y, seg.end_y);
			steps_q <= '0;
		end else begin
			if (cmd.adv) begin
				mx_q    <= mid_x;
				my_q    <= mid_y;
				steps_q <= steps_q + 1'b1;
			end
			if (cmd.upd) begin
				if (keep_p2) begin
					p1x_q <= mx_q;
					p1y_q <= my_q;
				end else begin
					p2x_q <= mx_q;
					p2y_q <= my_q;
				end
			end
		end
		if (cmd.lat_sq) begin
			r2_q   <= pa_q[scb_pkg::R2_W-1:0];
			tol2_q <= pb_q[scb_pkg::R2_W-1:0];
		end
		if (cmd.lat_s1) s1_q <= side_cur;
		// take the second end's side on the first length pass only
		if (cmd.lat_s2 && steps_q == '0) s2_q <= side_cur;
		if (cmd.res_wr) code_q <= cmd.res_code;
		if (cmd.out_load) begin
			if (code_q == scb_pkg::RES_SAME_SIDE) begin
				res_q.cross_x    <= '0;
				res_q.cross_y    <= '0;
				res_q.steps_used <= '0;
			end else begin
				res_q.cross_x    <= mx_q;
				res_q.cross_y    <= my_q;
				res_q.steps_used <= steps_q;
			end
			res_q.status <= code_q;
		end
	end

	assign res = res_q;

endmodule

// ===== rtl/core/segment_circle_bisection_core.sv =====
// ----------------------------------------------------------------------------
// segment_circle_bisection_core
// Each item runs setup (radius and tolerance squared, both end sides), then
// halvings of length, check and midpoint states until a midpoint lands on
// the circle, the interval is within tolerance or MAX_STEPS halvings are done;
// endpoints on the same side end the search. A new item is taken the cycle
// after the previous one reaches the output register: one item at a time.
// Reset: radius 1.0, tolerance 16, output empty.
// ----------------------------------------------------------------------------
module segment_circle_bisection_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      seg_valid,
	output logic                      seg_ready,
	input  scb_pkg::seg_t             seg,
	output logic                      res_valid,
	input  logic                      res_ready,
	output scb_pkg::res_t             res,
	input  logic                      cfg_wen,
	input  logic [0:0]                cfg_idx,
	input  logic [scb_pkg::CFG_W-1:0] cfg_wdata
);

	scb_pkg::cmd_t   cmd;
	scb_pkg::flags_t flags;

	scb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (seg_valid),
		.seg_ready (seg_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.flags     (flags),
		.cmd       (cmd)
	);

	scb_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.seg       (seg),
		.cmd       (cmd),
		.flags     (flags),
		.res       (res)
	);

endmodule
